FILE: design/tcd_pkg.sv
// ---------------------------------------------------------------------------
// tcd_pkg: shared types and constants of the text command decoder
// Keyword tables, action codes, the command summary that passes from the
// front end to the back end, and the queue status group.
// ---------------------------------------------------------------------------
package tcd_pkg;

    // Keyword set and table geometry.
    localparam int NUM_KEYS   = 6;
    localparam int NUM_SWITCH = 4;
    localparam int KEY_PWM    = 4;
    localparam int KEY_SPEECH = 5;
    localparam int KEY_MAX    = 11;

    // Queue between the front and back ends.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    // Characters with a meaning of their own.
    localparam logic [7:0] CHAR_NUL  = 8'h00;
    localparam logic [7:0] CHAR_OFF  = 8'h30;
    localparam logic [7:0] CHAR_ON   = 8'h31;
    localparam logic [7:0] CHAR_TOG  = 8'h32;
    localparam logic [15:0] DIGIT_BASE = 16'd48;

    // Action codes for a switch output.
    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_OFF    = 2'd1;
    localparam logic [1:0] ACT_ON     = 2'd2;
    localparam logic [1:0] ACT_TOGGLE = 2'd3;

    // Keyword text, padded with zero bytes, in the order relay, red lamp,
    // green lamp, yellow lamp, duty and speech.
    localparam logic [7:0] KEY_TEXT [NUM_KEYS][KEY_MAX] = '{
        '{8'h72, 8'h65, 8'h6c, 8'h61, 8'h79, 8'h3a, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h6c, 8'h65, 8'h64, 8'h5f, 8'h72, 8'h65, 8'h64, 8'h3a, 8'h00, 8'h00, 8'h00},
        '{8'h6c, 8'h65, 8'h64, 8'h5f, 8'h67, 8'h72, 8'h65, 8'h65, 8'h6e, 8'h3a, 8'h00},
        '{8'h6c, 8'h65, 8'h64, 8'h5f, 8'h79, 8'h65, 8'h6c, 8'h6c, 8'h6f, 8'h77, 8'h3a},
        '{8'h70, 8'h77, 8'h6d, 8'h3a, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h73, 8'h70, 8'h65, 8'h61, 8'h63, 8'h68, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [3:0] KEY_LEN [NUM_KEYS] = '{4'd6, 4'd8, 4'd10, 4'd11, 4'd4, 4'd6};

    // Summary of one finished command, produced at its last beat.
    typedef struct packed {
        logic [NUM_SWITCH-1:0][1:0] action;
        logic                       duty_load;
        logic [15:0]                duty;
        logic                       speech;
    } cmd_summary_t;

    // Queue fill status seen by both ends.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Next matched length of keyword k after byte c, with p bytes matched
    // (p below the keyword length). Falls back to the longest prefix that
    // is also a suffix of the matched text followed by c.
    function automatic logic [3:0] key_advance(input int k, input logic [3:0] p,
                                               input logic [7:0] c);
        logic [3:0] res;
        logic       ok;
        res = 4'd0;
        for (int pp = 0; pp < KEY_MAX; pp++) begin
            if ((pp < int'(KEY_LEN[k])) && (p == 4'(pp))) begin
                for (int n = 1; n <= pp; n++) begin
                    ok = 1'b1;
                    for (int j = 0; j < n - 1; j++) begin
                        if (KEY_TEXT[k][j] != KEY_TEXT[k][pp - n + 1 + j]) begin
                            ok = 1'b0;
                        end
                    end
                    if (ok && (KEY_TEXT[k][n - 1] == c)) begin
                        res = 4'(n);
                    end
                end
                if (KEY_TEXT[k][pp] == c) begin
                    res = 4'(pp + 1);
                end
            end
        end
        return res;
    endfunction

endpackage

FILE: design/tcd_front.sv
// ---------------------------------------------------------------------------
// tcd_front: keyword matchers and per-command state
// Runs the six keyword matchers on each byte before the end, records actions and
// the duty value, and hands a command summary to the queue at the last beat.
// ---------------------------------------------------------------------------
module tcd_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_fire,
    input  logic [7:0]            char_byte,
    input  logic                  is_last,
    output logic                  push,
    output tcd_pkg::cmd_summary_t cmd
);

    logic [3:0]  progress_reg [tcd_pkg::NUM_KEYS];
    logic [3:0]  progress_next [tcd_pkg::NUM_KEYS];
    logic [3:0]  progress_work [tcd_pkg::NUM_KEYS];
    logic [tcd_pkg::NUM_KEYS-1:0] found_reg, found_next, found_work;
    logic [1:0]  action_reg [tcd_pkg::NUM_SWITCH];
    logic [1:0]  action_next [tcd_pkg::NUM_SWITCH];
    logic [1:0]  action_work [tcd_pkg::NUM_SWITCH];
    logic [1:0]  digits_reg, digits_next, digits_work;
    logic [15:0] acc_reg, acc_next, acc_work;
    logic        ended_reg, ended_next, ended_work;
    logic        take;
    logic [3:0]  start;

    // A byte goes to the matchers only before the text has ended.
    assign take = in_fire && !ended_reg && (char_byte != tcd_pkg::CHAR_NUL);

    // Per-beat update of the matchers, actions and duty digits.
    always_comb
    begin
        progress_work = progress_reg;
        found_work    = found_reg;
        action_work   = action_reg;
        digits_work   = digits_reg;
        acc_work      = acc_reg;
        ended_work    = ended_reg;
        start         = 4'd0;

        if (in_fire && !ended_reg && (char_byte == tcd_pkg::CHAR_NUL))
        begin
            ended_work = 1'b1;
        end

        if (take)
        begin
            // Matchers still searching for their keyword.
            for (int k = 0; k < tcd_pkg::NUM_KEYS; k++)
            begin
                if (!found_reg[k])
                begin
                    start = (progress_reg[k] >= tcd_pkg::KEY_LEN[k]) ? 4'd0 : progress_reg[k];
                    progress_work[k] = tcd_pkg::key_advance(k, start, char_byte);
                    if (progress_work[k] == tcd_pkg::KEY_LEN[k])
                    begin
                        found_work[k] = 1'b1;
                    end
                end
            end

            // The byte after a switch keyword is its action.
            for (int k = 0; k < tcd_pkg::NUM_SWITCH; k++)
            begin
                if (found_reg[k] && (progress_reg[k] == tcd_pkg::KEY_LEN[k]))
                begin
                    priority if (char_byte == tcd_pkg::CHAR_OFF)
                        action_work[k] = tcd_pkg::ACT_OFF;
                    else if (char_byte == tcd_pkg::CHAR_ON)
                        action_work[k] = tcd_pkg::ACT_ON;
                    else if (char_byte == tcd_pkg::CHAR_TOG)
                        action_work[k] = tcd_pkg::ACT_TOGGLE;
                    else
                        action_work[k] = action_reg[k];
                    progress_work[k] = 4'd0;
                end
            end

            // Three bytes after the duty keyword build the duty value.
            if (found_reg[tcd_pkg::KEY_PWM] &&
                (progress_reg[tcd_pkg::KEY_PWM] == tcd_pkg::KEY_LEN[tcd_pkg::KEY_PWM]))
            begin
                acc_work    = 16'(acc_reg * 16'd10 + {8'd0, char_byte} - tcd_pkg::DIGIT_BASE);
                digits_work = 2'(digits_reg + 2'd1);
                if (digits_work == 2'd3)
                begin
                    progress_work[tcd_pkg::KEY_PWM] = 4'd0;
                end
            end
        end
    end

    // Command summary at the last beat.
    always_comb
    begin
        for (int k = 0; k < tcd_pkg::NUM_SWITCH; k++)
        begin
            cmd.action[k] = action_work[k];
        end
        cmd.duty_load = found_work[tcd_pkg::KEY_PWM] && (digits_work == 2'd3);
        cmd.duty      = acc_work;
        cmd.speech    = found_work[tcd_pkg::KEY_SPEECH];
    end

    assign push = in_fire && is_last;

    // The last beat clears the per-command state.
    always_comb
    begin
        for (int k = 0; k < tcd_pkg::NUM_KEYS; k++)
        begin
            progress_next[k] = push ? 4'd0 : progress_work[k];
        end
        for (int k = 0; k < tcd_pkg::NUM_SWITCH; k++)
        begin
            action_next[k] = push ? tcd_pkg::ACT_NONE : action_work[k];
        end
        found_next  = push ? '0 : found_work;
        digits_next = push ? 2'd0 : digits_work;
        acc_next    = push ? 16'd0 : acc_work;
        ended_next  = push ? 1'b0 : ended_work;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < tcd_pkg::NUM_KEYS; k++)
            begin
                progress_reg[k] <= 4'd0;
            end
            for (int k = 0; k < tcd_pkg::NUM_SWITCH; k++)
            begin
                action_reg[k] <= tcd_pkg::ACT_NONE;
            end
            found_reg  <= '0;
            digits_reg <= 2'd0;
            acc_reg    <= 16'd0;
            ended_reg  <= 1'b0;
        end
        else
        begin
            progress_reg <= progress_next;
            action_reg   <= action_next;
            found_reg    <= found_next;
            digits_reg   <= digits_next;
            acc_reg      <= acc_next;
            ended_reg    <= ended_next;
        end
    end

endmodule

FILE: design/tcd_queue.sv
// ---------------------------------------------------------------------------
// tcd_queue: command summary queue
// A short first-in first-out queue that lets the front end keep taking
// beats while the back end waits on a stalled output.
// ---------------------------------------------------------------------------
module tcd_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  tcd_pkg::cmd_summary_t  push_data,
    input  logic                   pop,
    output tcd_pkg::cmd_summary_t  pop_data,
    output tcd_pkg::queue_status_t status
);

    tcd_pkg::cmd_summary_t             entry_reg [tcd_pkg::QUEUE_DEPTH];
    logic [tcd_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [tcd_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [tcd_pkg::QUEUE_CNT_W-1:0]   count_reg, count_next;

    // Fill status.
    assign status.full  = (count_reg == tcd_pkg::QUEUE_CNT_W'(tcd_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_data     = entry_reg[rd_ptr_reg];

    // Pointer and count update; the depth is a power of two, so pointers wrap.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: design/tcd_back.sv
// ---------------------------------------------------------------------------
// tcd_back: command execution and output register
// Applies a command summary to the switch states and the duty register and
// presents the result beat until the receiver takes it.
// ---------------------------------------------------------------------------
module tcd_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tcd_pkg::queue_status_t q_status,
    input  tcd_pkg::cmd_summary_t  cmd,
    output logic                   pop,
    input  logic                   out_stall,
    output logic                   out_valid,
    output logic                   relay_on,
    output logic                   red_on,
    output logic                   green_on,
    output logic                   yellow_on,
    output logic [15:0]            duty_value,
    output logic                   speech_request,
    output logic                   status_report
);

    logic [tcd_pkg::NUM_SWITCH-1:0] switch_reg, switch_next;
    logic [15:0]                    duty_reg, duty_next;
    logic                           speech_reg;
    logic                           valid_reg, valid_next;

    // Take a summary when the output register is free or being emptied.
    assign pop = !q_status.empty && (!valid_reg || !out_stall);

    // Apply the actions in switch order, then the duty value.
    always_comb
    begin
        switch_next = switch_reg;
        for (int k = 0; k < tcd_pkg::NUM_SWITCH; k++)
        begin
            unique case (cmd.action[k])
                tcd_pkg::ACT_OFF:    switch_next[k] = 1'b0;
                tcd_pkg::ACT_ON:     switch_next[k] = 1'b1;
                tcd_pkg::ACT_TOGGLE: switch_next[k] = ~switch_reg[k];
                tcd_pkg::ACT_NONE:   switch_next[k] = switch_reg[k];
            endcase
        end
        duty_next  = cmd.duty_load ? cmd.duty : duty_reg;
        valid_next = pop ? 1'b1 : (valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            switch_reg <= '0;
            duty_reg   <= 16'd0;
            speech_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (pop)
            begin
                switch_reg <= switch_next;
                duty_reg   <= duty_next;
                speech_reg <= cmd.speech;
            end
        end
    end

    // The state registers double as the result beat.
    assign out_valid      = valid_reg;
    assign relay_on       = switch_reg[0];
    assign red_on         = switch_reg[1];
    assign green_on       = switch_reg[2];
    assign yellow_on      = switch_reg[3];
    assign duty_value     = duty_reg;
    assign speech_request = speech_reg;
    assign status_report  = ~speech_reg;

endmodule

FILE: design/text_command_decoder_core.sv
// ---------------------------------------------------------------------------
// text_command_decoder_core: byte-wise text command decoder
// Decodes switch, duty and speech keywords from a command text and reports
// the resulting output states once per command.
// ---------------------------------------------------------------------------
// Usage:
// The input channel carries one text byte per beat (char_byte) with is_last
// marking the final byte of a command. The output channel carries one beat
// per command: the four switch states, the duty value and the speech and
// status flags. Both channels use valid and stall.
// Throughput: one input byte per cycle while in_stall is low, set by the six keyword
// matchers that all work on the same byte together.
// A summary is written into the two-entry queue when its last byte is taken;
// the back end then moves it into the output register, which holds the result
// beat, once that register is free or being emptied.
// When the receiver stalls, the result beat holds, the queue fills, and
// in_stall rises only once both queue entries are taken; from then on every
// byte, last or not, waits for a free entry.
// Reset clears all switch states, the duty value and any partial command.
// ---------------------------------------------------------------------------
module text_command_decoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_byte,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        relay_on,
    output logic        red_on,
    output logic        green_on,
    output logic        yellow_on,
    output logic [15:0] duty_value,
    output logic        speech_request,
    output logic        status_report
);

    tcd_pkg::cmd_summary_t  push_cmd;
    tcd_pkg::cmd_summary_t  pop_cmd;
    tcd_pkg::queue_status_t q_status;
    logic                   in_fire;
    logic                   push;
    logic                   pop;

    // Input beats wait only when the queue is full.
    assign in_stall = q_status.full;
    assign in_fire  = in_valid && !in_stall;

    tcd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .char_byte (char_byte),
        .is_last   (is_last),
        .push      (push),
        .cmd       (push_cmd)
    );

    tcd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .pop_data  (pop_cmd),
        .status    (q_status)
    );

    tcd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_status       (q_status),
        .cmd            (pop_cmd),
        .pop            (pop),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .relay_on       (relay_on),
        .red_on         (red_on),
        .green_on       (green_on),
        .yellow_on      (yellow_on),
        .duty_value     (duty_value),
        .speech_request (speech_request),
        .status_report  (status_report)
    );

`ifndef ASSERT_OFF
    // A taken last byte always leaves a summary waiting in the queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && is_last) |=> !q_status.empty)
        else $error("last byte taken but queue is empty");

    // A new result beat appears only after a summary was queued.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!q_status.empty))
        else $error("result beat without a queued command");

    // The back end never takes from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("queue read while empty");
`endif

endmodule

FILE: verif/text_command_decoder_core_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for text_command_decoder_core
// Sends command texts one byte per beat. The texts are mostly well-formed
// keyword phrases with random content, mixed with noise, broken keywords and
// zero bytes. A scoreboard predicts the result beat of every command and
// checks each received result field by field. Both sides idle at random.
// ---------------------------------------------------------------------------
module testbench;

    // Keyword slots of the green and yellow lamps.
    localparam int KEY_GREEN  = 2;
    localparam int KEY_YELLOW = 3;

    // Fields of one result beat.
    typedef struct {
        bit          relay;
        bit          red;
        bit          green;
        bit          yellow;
        logic [15:0] duty;
        bit          speech;
        bit          status;
    } result_t;

    // Predicts the decoder output of each command and checks the received beats.
    class command_scoreboard;
        string       keyword [tcd_pkg::NUM_KEYS];
        int unsigned progress [tcd_pkg::NUM_KEYS];
        bit          found [tcd_pkg::NUM_KEYS];
        logic [1:0]  action [tcd_pkg::NUM_SWITCH];
        int unsigned digits;
        logic [15:0] duty_acc;
        bit          ended;
        logic [3:0]  switches;
        logic [15:0] duty_reg;
        result_t     expected_q [$];
        int          errors;

        function new();
            for (int k = 0; k < tcd_pkg::NUM_KEYS; k++)
            begin
                keyword[k] = "";
                for (int i = 0; i < int'(tcd_pkg::KEY_LEN[k]); i++)
                    keyword[k] = $sformatf("%s%c", keyword[k], tcd_pkg::KEY_TEXT[k][i]);
            end
            clear_command();
            switches = 4'd0;
            duty_reg = 16'd0;
            errors   = 0;
        endfunction

        function void clear_command();
            for (int k = 0; k < tcd_pkg::NUM_KEYS; k++)
            begin
                progress[k] = 0;
                found[k]    = 1'b0;
            end
            for (int k = 0; k < tcd_pkg::NUM_SWITCH; k++)
            begin
                action[k] = tcd_pkg::ACT_NONE;
            end
            digits   = 0;
            duty_acc = 16'd0;
            ended    = 1'b0;
        endfunction

        // Matched length of keyword k after byte c when p bytes were matched.
        // On a mismatch it falls back to the longest keyword prefix that ends
        // the matched text followed by c.
        function int unsigned next_progress(int k, int unsigned p, logic [7:0] c);
            string w;
            bit    same;
            w = keyword[k];
            if (w[p] == c)
                return p + 1;
            for (int n = p; n > 0; n--)
            begin
                if (w[n - 1] == c)
                begin
                    same = 1'b1;
                    for (int j = 0; j < n - 1; j++)
                    begin
                        if (w[j] != w[p - n + 1 + j])
                            same = 1'b0;
                    end
                    if (same)
                        return n;
                end
            end
            return 0;
        endfunction

        function void take_byte(logic [7:0] c);
            int unsigned p;
            int unsigned len;
            for (int k = 0; k < tcd_pkg::NUM_KEYS; k++)
            begin
                p   = progress[k];
                len = keyword[k].len();
                if (found[k])
                begin
                    // Only the bytes right after the first occurrence count.
                    if (p != len || k == tcd_pkg::KEY_SPEECH)
                        continue;
                    if (k == tcd_pkg::KEY_PWM)
                    begin
                        duty_acc = 16'(duty_acc * 16'd10 + {8'd0, c} - tcd_pkg::DIGIT_BASE);
                        digits   = (digits + 1) & 3;
                        if (digits == 3)
                            progress[k] = 0;
                    end
                    else
                    begin
                        if (c == tcd_pkg::CHAR_OFF)
                            action[k] = tcd_pkg::ACT_OFF;
                        else if (c == tcd_pkg::CHAR_ON)
                            action[k] = tcd_pkg::ACT_ON;
                        else if (c == tcd_pkg::CHAR_TOG)
                            action[k] = tcd_pkg::ACT_TOGGLE;
                        progress[k] = 0;
                    end
                end
                else
                begin
                    if (p >= len)
                        p = 0;
                    p = next_progress(k, p, c);
                    progress[k] = p & 15;
                    if (p == len)
                        found[k] = 1'b1;
                end
            end
        endfunction

        // Notes one accepted input beat; the last beat of a command queues a result.
        function void note_byte(logic [7:0] c, bit last);
            result_t res;
            if (!ended)
            begin
                if (c == tcd_pkg::CHAR_NUL)
                    ended = 1'b1;
                else
                    take_byte(c);
            end
            if (!last)
                return;
            for (int k = 0; k < tcd_pkg::NUM_SWITCH; k++)
            begin
                if (!found[k])
                    continue;
                unique case (action[k])
                    tcd_pkg::ACT_OFF:    switches[k] = 1'b0;
                    tcd_pkg::ACT_ON:     switches[k] = 1'b1;
                    tcd_pkg::ACT_TOGGLE: switches[k] = ~switches[k];
                    default:             ;
                endcase
            end
            if (found[tcd_pkg::KEY_PWM] && digits == 3)
                duty_reg = duty_acc;
            res.relay  = switches[0];
            res.red    = switches[1];
            res.green  = switches[2];
            res.yellow = switches[3];
            res.duty   = duty_reg;
            res.speech = found[tcd_pkg::KEY_SPEECH];
            res.status = !found[tcd_pkg::KEY_SPEECH];
            expected_q.push_back(res);
            clear_command();
        endfunction

        function void check_field(string name, int unsigned exp_v, int unsigned got_v);
            if (exp_v != got_v)
            begin
                $error("%s: expected %0d, got %0d", name, exp_v, got_v);
                errors++;
            end
        endfunction

        // Checks one accepted result beat against the oldest prediction.
        function void check_result(result_t got);
            result_t exp_r;
            if (expected_q.size() == 0)
            begin
                $error("result beat with no command pending");
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            check_field("relay_on", exp_r.relay, got.relay);
            check_field("red_on", exp_r.red, got.red);
            check_field("green_on", exp_r.green, got.green);
            check_field("yellow_on", exp_r.yellow, got.yellow);
            check_field("duty_value", exp_r.duty, got.duty);
            check_field("speech_request", exp_r.speech, got.speech);
            check_field("status_report", exp_r.status, got.status);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  char_byte;
    logic        is_last;
    logic        out_valid;
    logic        out_stall;
    logic        relay_on;
    logic        red_on;
    logic        green_on;
    logic        yellow_on;
    logic [15:0] duty_value;
    logic        speech_request;
    logic        status_report;

    command_scoreboard sb;
    logic [7:0]  text_buf [$];
    bit          calm;
    int          bytes_sent;
    int          stall_left;
    result_t     seen;

    text_command_decoder_core dut (.*);

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #3_000_000;
        $display("text_command_decoder_core verification failed");
        $finish;
    end

    // Idle length: mostly none, some short, a few long; none while calm.
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function void add_text(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            text_buf.push_back(s[i]);
        end
    endfunction

    function void add_byte(logic [7:0] b);
        text_buf.push_back(b);
    endfunction

    // Sends one beat after a random gap and waits until it is taken.
    task automatic send_byte(logic [7:0] c, bit last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_byte <= c;
        is_last   <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_byte(c, last);
        bytes_sent++;
    endtask

    // Sends the buffered text as one command, marking its final byte.
    task automatic send_text();
        int n;
        n = text_buf.size();
        for (int i = 0; i < n; i++)
        begin
            send_byte(text_buf[i], i == n - 1);
        end
        text_buf.delete();
    endtask

    task automatic wait_drained();
        while (sb.pending() > 0)
            @(posedge clk);
    endtask

    // Builds one random command from keyword phrases, noise and broken keywords.
    function void build_command();
        int nfrag;
        int r;
        int k;
        int cut;
        int ndig;
        nfrag = $urandom_range(1, 4);
        for (int f = 0; f < nfrag; f++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                k = $urandom_range(0, tcd_pkg::NUM_SWITCH - 1);
                add_text(sb.keyword[k]);
                r = $urandom_range(0, 99);
                if (r < 80)
                    add_byte(tcd_pkg::CHAR_OFF + 8'($urandom_range(0, 2)));
                else if (r < 92)
                    add_byte(8'($urandom_range(1, 255)));
            end
            else if (r < 60)
            begin
                add_text(sb.keyword[tcd_pkg::KEY_PWM]);
                ndig = ($urandom_range(0, 9) < 8) ? 3 : $urandom_range(0, 2);
                for (int d = 0; d < ndig; d++)
                begin
                    if ($urandom_range(0, 9) < 8)
                        add_byte(tcd_pkg::CHAR_OFF + 8'($urandom_range(0, 9)));
                    else
                        add_byte(8'($urandom_range(1, 255)));
                end
            end
            else if (r < 68)
            begin
                add_text(sb.keyword[tcd_pkg::KEY_SPEECH]);
            end
            else if (r < 80)
            begin
                // Broken keyword: a proper prefix of a random keyword.
                k = $urandom_range(0, tcd_pkg::NUM_KEYS - 1);
                cut = $urandom_range(1, sb.keyword[k].len() - 1);
                add_text(sb.keyword[k].substr(0, cut - 1));
            end
            else if (r < 94)
            begin
                repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(1, 255)));
            end
            else
            begin
                add_byte(tcd_pkg::CHAR_NUL);
            end
        end
    endfunction

    // Result side: checks accepted beats and stalls at random.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen.relay  = relay_on;
            seen.red    = red_on;
            seen.green  = green_on;
            seen.yellow = yellow_on;
            seen.duty   = duty_value;
            seen.speech = speech_request;
            seen.status = status_report;
            sb.check_result(seen);
        end
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall  <= 1'b0;
            stall_left = pick_gap();
        end
    end

    // Stimulus.
    initial
    begin
        sb         = new();
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        char_byte  = 8'd0;
        is_last    = 1'b0;
        out_stall  = 1'b0;
        stall_left = 0;
        bytes_sent = 0;
        calm       = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: byte extremes, every action, duty wrap, the corner cases.
        add_byte(8'hff);
        send_text();
        add_byte(tcd_pkg::CHAR_NUL);
        send_text();
        add_text("relay:1led_red:1");
        add_text(sb.keyword[KEY_GREEN]);
        add_text("1");
        add_text(sb.keyword[KEY_YELLOW]);
        add_text("1pwm:123");
        send_text();
        add_text("relay:2led_red:0");
        add_text(sb.keyword[KEY_GREEN]);
        add_text("2");
        add_text(sb.keyword[KEY_YELLOW]);
        add_text("9speach");
        send_text();
        add_text("pwm:");
        repeat (3) add_byte(8'hff);
        send_text();
        // Short duty value keeps the old one.
        add_text("pwm:12");
        send_text();
        // Keyword as the very last byte does nothing.
        add_text("relay:");
        send_text();
        // Only the first occurrence counts.
        add_text("relay:0relay:1");
        send_text();
        // A zero byte ends the text early.
        add_text("led_red:");
        add_byte(tcd_pkg::CHAR_NUL);
        add_text("1speach");
        send_text();
        // Overlapping prefixes need the matcher to fall back.
        add_text("rerelay:2led_led_red:2spspeachpwpwm:000");
        send_text();

        // Let every result arrive before going on.
        in_valid <= 1'b0;
        wait_drained();
        @(posedge clk);

        // Random commands, with calm stretches now and then.
        while (bytes_sent < 1750)
        begin
            calm = ($urandom_range(0, 7) == 0);
            build_command();
            if (text_buf.size() == 0)
                add_byte(8'($urandom_range(0, 255)));
            send_text();
        end
        in_valid <= 1'b0;

        wait_drained();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("text_command_decoder_core verification clean");
        else
            $display("text_command_decoder_core verification failed");
        $finish;
    end
endmodule
